// ===== src/rdu_pkg.sv =====
`timescale 1ns / 1ps

package rdu_pkg;

   // Operand width; one pipeline stage per quotient bit.
   localparam int unsigned DATA_WIDTH = 32;

   // Number of division stages, one per quotient bit.
   localparam int unsigned STAGE_COUNT = DATA_WIDTH;

   // What travels between division stages.
   // The working word holds the dividend bits that have not yet been used in
   // its upper part and the quotient bits found so far in its lower part.
   typedef struct packed {
      logic                    valid;
      logic [DATA_WIDTH-1:0]   partial;
      logic [DATA_WIDTH-1:0]   work;
      logic [DATA_WIDTH-1:0]   divisor;
   } rdu_stage_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]   quotient;
      logic [DATA_WIDTH-1:0]   remainder;
   } rdu_result_type;

endpackage

// ===== src/rdu_req_if.sv =====
`timescale 1ns / 1ps

interface rdu_req_if;

   logic                          valid;
   logic                          ready;
   logic [rdu_pkg::DATA_WIDTH-1:0] dividend;
   logic [rdu_pkg::DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink (input valid, input dividend, input divisor, output ready);

endinterface

// ===== src/rdu_rsp_if.sv =====
`timescale 1ns / 1ps

interface rdu_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [rdu_pkg::DATA_WIDTH-1:0] quotient;
   logic [rdu_pkg::DATA_WIDTH-1:0] remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink (input valid, input quotient, input remainder, output ready);

endinterface

// ===== src/rdu_stage.sv =====
`timescale 1ns / 1ps

module rdu_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rdu_pkg::rdu_stage_type stage_in,
   output rdu_pkg::rdu_stage_type stage_out
);

   logic [rdu_pkg::DATA_WIDTH:0]   trial;
   logic [rdu_pkg::DATA_WIDTH:0]   diff;
   logic                           take;
   logic                           valid_ff;
   logic                           valid_in;
   logic [rdu_pkg::DATA_WIDTH-1:0] partial_ff;
   logic [rdu_pkg::DATA_WIDTH-1:0] partial_in;
   logic [rdu_pkg::DATA_WIDTH-1:0] work_ff;
   logic [rdu_pkg::DATA_WIDTH-1:0] work_in;
   logic [rdu_pkg::DATA_WIDTH-1:0] divisor_ff;

   // Shift the next dividend bit into the partial remainder, keeping the
   // carry bit so that the compare sees the true value.
   assign trial = {stage_in.partial, stage_in.work[rdu_pkg::DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, stage_in.divisor};
   assign take  = ~diff[rdu_pkg::DATA_WIDTH];

   assign partial_in = take ? diff[rdu_pkg::DATA_WIDTH-1:0]
                            : trial[rdu_pkg::DATA_WIDTH-1:0];
   assign work_in    = {stage_in.work[rdu_pkg::DATA_WIDTH-2:0], take};
   assign valid_in   = stage_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         partial_ff <= partial_in;
         work_ff    <= work_in;
         divisor_ff <= stage_in.divisor;
      end
   end

   assign stage_out.valid   = valid_ff;
   assign stage_out.partial = partial_ff;
   assign stage_out.work    = work_ff;
   assign stage_out.divisor = divisor_ff;

endmodule

// ===== src/rdu_out_buffer.sv =====
`timescale 1ns / 1ps

module rdu_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  rdu_pkg::rdu_result_type push_data,
   output logic                   space,
   rdu_rsp_if.source              rsp_ch
);

   logic                    out_valid_ff;
   logic                    out_valid_in;
   rdu_pkg::rdu_result_type out_data_ff;
   rdu_pkg::rdu_result_type out_data_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   rdu_pkg::rdu_result_type skid_data_ff;
   rdu_pkg::rdu_result_type skid_data_in;
   logic                    pop;
   logic                    push;

   // The pipeline only moves while the skid register is empty.
   assign space = ~skid_valid_ff;
   assign push  = push_valid & space;
   assign pop   = out_valid_ff & rsp_ch.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.quotient  = out_data_ff.quotient;
   assign rsp_ch.remainder = out_data_ff.remainder;

endmodule

// ===== src/restoring_divider_unit.sv =====
`timescale 1ns / 1ps

// Unsigned 32-bit restoring divider, fully pipelined.
// A request on req_ch carries a dividend and a divisor; it is taken at a
// rising clock edge at which valid and ready are both high. For every request
// exactly one response leaves on rsp_ch with the quotient and the remainder,
// in request order. A zero divisor is not flagged: it yields a quotient of
// all ones and a remainder equal to the dividend.
// A request is captured at the accepting edge by the first of 32 pipeline
// stages (one per quotient bit, each one 33-bit subtract and select), and the
// output register takes the finished result from the last stage. Throughput
// is one request per cycle while the skid register is empty.
// When the receiver stalls, the output register holds its response and the
// next finished response drops into a skid register; only while the skid
// register is full does req_ch.ready go low and the whole pipeline freeze, so
// nothing is lost or repeated. req_ch.ready never depends on rsp_ch.ready in
// the same cycle.
// Synchronous active-high reset empties the pipeline and both output
// registers; a request may be offered in the first cycle after reset.
module restoring_divider_unit (
   input  logic       clock,
   input  logic       reset,
   rdu_req_if.sink    req_ch,
   rdu_rsp_if.source  rsp_ch
);

   rdu_pkg::rdu_stage_type  stage_chain [0:rdu_pkg::STAGE_COUNT];
   rdu_pkg::rdu_result_type final_result;
   logic                    advance;

   // The first stage starts with an empty partial remainder and the whole
   // dividend waiting in the working word.
   assign stage_chain[0].valid   = req_ch.valid;
   assign stage_chain[0].partial = '0;
   assign stage_chain[0].work    = req_ch.dividend;
   assign stage_chain[0].divisor = req_ch.divisor;

   assign req_ch.ready = advance;

   // One stage for each quotient bit, most significant bit first.
   for (genvar k = 0; k < rdu_pkg::STAGE_COUNT; k++) begin : g_stage
      rdu_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage_chain[k]),
         .stage_out (stage_chain[k+1])
      );
   end

   // After the last step the working word is the quotient.
   assign final_result.quotient  = stage_chain[rdu_pkg::STAGE_COUNT].work;
   assign final_result.remainder = stage_chain[rdu_pkg::STAGE_COUNT].partial;

   rdu_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (stage_chain[rdu_pkg::STAGE_COUNT].valid),
      .push_data  (final_result),
      .space      (advance),
      .rsp_ch     (rsp_ch)
   );

   // A frozen pipeline means the output register is holding a response.
   a_stall_has_output : assert property (
      @(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid
   ) else $error("pipeline frozen without a pending response");

   // The pipeline only freezes after the receiver refused a response.
   a_stall_cause : assert property (
      @(posedge clock) disable iff (reset)
      !req_ch.ready |-> $past(rsp_ch.valid && !rsp_ch.ready)
   ) else $error("pipeline frozen without a refused response");

   // After a finished division leaves the last stage, a response is presented next cycle.
   a_last_stage_delivers : assert property (
      @(posedge clock) disable iff (reset)
      (stage_chain[rdu_pkg::STAGE_COUNT].valid && advance) |=> rsp_ch.valid
   ) else $error("finished division not presented");

endmodule
